### hw/rtl/tprc_pkg.sv
// Shared types, sizes and helpers for the top partner run counter.
// No dependencies; every other file in hw/rtl imports this package.
package tprc_pkg;

  localparam int TOP_K        = 10;
  localparam int NODE_ID_BITS = 20;
  localparam int CNT_W        = 32;
  localparam int RANK_W       = 4;
  localparam int IDX_W        = (TOP_K > 1) ? $clog2(TOP_K) : 1;
  localparam int FIFO_DEPTH   = 4;
  localparam int FIFO_AW      = $clog2(FIFO_DEPTH);

  typedef logic [NODE_ID_BITS-1:0] id_t;
  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic [IDX_W-1:0]        idx_t;

  // one queue entry: a closed run to offer, and the final run on a source's last link
  typedef struct packed {
    logic close_v;
    id_t  close_id;
    cnt_t close_cnt;
    logic fin;
    id_t  fin_id;
    cnt_t fin_cnt;
    id_t  src;
    cnt_t total;
  } tprc_ofr_t;

  typedef enum logic [1:0] {
    B_TAKE,
    B_FIN,
    B_EMIT
  } back_state_t;

  function automatic cnt_t sat_inc(cnt_t v);
    return (&v) ? v : cnt_t'(v + 1'b1);
  endfunction

  // strict ranking: larger count first, larger id wins a tie
  function automatic logic better(cnt_t ca, id_t ia, cnt_t cb, id_t ib);
    return (ca != cb) ? (ca > cb) : (ia > ib);
  endfunction

endpackage

### hw/rtl/tprc_front.sv
// Front end: accepts link beats, counts runs and link totals per source.
// Pushes closed runs and source closures into the offer queue. Uses tprc_pkg.
module tprc_front
  import tprc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  id_t       in_src_id,
  input  id_t       in_dst_id,
  input  logic      in_last_of_source,
  input  logic      q_full,
  output logic      q_push,
  output tprc_ofr_t q_data
);

  id_t  rp_r,  rp_nxt;
  cnt_t len_r, len_nxt;
  cnt_t tot_r, tot_nxt;
  logic grp_r, grp_nxt;

  logic acc;
  id_t  cur_id;
  cnt_t cur_len;
  cnt_t cur_tot;
  logic close_v;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;

  always_comb begin
    close_v = 1'b0;
    if (!grp_r) begin
      cur_id  = in_dst_id;
      cur_len = cnt_t'(1);
      cur_tot = cnt_t'(1);
    end else begin
      cur_tot = sat_inc(tot_r);
      if (in_dst_id == rp_r) begin
        cur_id  = rp_r;
        cur_len = sat_inc(len_r);
      end else begin
        close_v = 1'b1;
        cur_id  = in_dst_id;
        cur_len = cnt_t'(1);
      end
    end

    q_data.close_v   = close_v;
    q_data.close_id  = rp_r;
    q_data.close_cnt = len_r;
    q_data.fin       = in_last_of_source;
    q_data.fin_id    = cur_id;
    q_data.fin_cnt   = cur_len;
    q_data.src       = in_src_id;
    q_data.total     = cur_tot;
    q_push           = acc && (close_v || in_last_of_source);

    rp_nxt  = rp_r;
    len_nxt = len_r;
    tot_nxt = tot_r;
    grp_nxt = grp_r;
    if (acc) begin
      if (in_last_of_source) begin
        rp_nxt  = '0;
        len_nxt = '0;
        tot_nxt = '0;
        grp_nxt = 1'b0;
      end else begin
        rp_nxt  = cur_id;
        len_nxt = cur_len;
        tot_nxt = cur_tot;
        grp_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_r  <= '0;
      len_r <= '0;
      tot_r <= '0;
      grp_r <= 1'b0;
    end else begin
      rp_r  <= rp_nxt;
      len_r <= len_nxt;
      tot_r <= tot_nxt;
      grp_r <= grp_nxt;
    end
  end

endmodule

### hw/rtl/tprc_fifo.sv
// Offer queue between front end and top list, FIFO_DEPTH entries.
// Entries are tprc_ofr_t from tprc_pkg.
module tprc_fifo
  import tprc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  tprc_ofr_t wr_data,
  input  logic      pop,
  output tprc_ofr_t rd_data,
  output logic      full,
  output logic      empty
);

  tprc_ofr_t mem [FIFO_DEPTH];

  logic [FIFO_AW-1:0] wp_r, wp_nxt;
  logic [FIFO_AW-1:0] rp_r, rp_nxt;
  logic [FIFO_AW:0]   cnt_r, cnt_nxt;
  logic               do_push;
  logic               do_pop;

  assign full    = (cnt_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rp_r];

  always_comb begin
    wp_nxt  = do_push ? FIFO_AW'(wp_r + 1'b1) : wp_r;
    rp_nxt  = do_pop  ? FIFO_AW'(rp_r + 1'b1) : rp_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = (FIFO_AW+1)'(cnt_r + 1'b1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = (FIFO_AW+1)'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp_r] <= wr_data;
    end
  end

endmodule

### hw/rtl/tprc_back.sv
// Back end: holds the ranked top list, inserts one offered run per cycle in B_TAKE,
// and drains the list as result beats through an output register. Uses tprc_pkg.
module tprc_back
  import tprc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  tprc_ofr_t         q_data,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output id_t               out_src_node,
  output cnt_t              out_total_links,
  output logic [RANK_W-1:0] out_rank,
  output id_t               out_partner_node,
  output cnt_t              out_partner_count,
  output logic              out_last
);

  back_state_t state_r, state_nxt;

  id_t  ids_r  [TOP_K];
  cnt_t cnts_r [TOP_K];
  id_t  ids_nxt  [TOP_K];
  cnt_t cnts_nxt [TOP_K];

  id_t  fin_id_r;
  cnt_t fin_cnt_r;
  id_t  src_r;
  cnt_t tot_r;
  idx_t e_r, e_nxt;

  logic              ov_r, ov_nxt;
  id_t               o_src_r;
  cnt_t              o_tot_r;
  logic [RANK_W-1:0] o_rank_r;
  id_t               o_id_r;
  cnt_t              o_cnt_r;
  logic              o_last_r;

  logic             ins_v;
  id_t              ins_id;
  cnt_t             ins_cnt;
  logic             cap;
  logic             load;
  logic             clr;
  logic [TOP_K-1:0] beat;
  logic [TOP_K:0]   filled;
  logic [TOP_K-1:0] em_last;

  always_comb begin
    ins_v     = 1'b0;
    ins_id    = q_data.close_id;
    ins_cnt   = q_data.close_cnt;
    q_pop     = 1'b0;
    cap       = 1'b0;
    load      = 1'b0;
    clr       = 1'b0;
    e_nxt     = e_r;
    state_nxt = state_r;
    case (state_r)
      B_TAKE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          ins_v = q_data.close_v;
          if (q_data.fin) begin
            cap       = 1'b1;
            state_nxt = B_FIN;
          end
        end
      end
      B_FIN: begin
        ins_v     = 1'b1;
        ins_id    = fin_id_r;
        ins_cnt   = fin_cnt_r;
        e_nxt     = '0;
        state_nxt = B_EMIT;
      end
      B_EMIT: begin
        if (!ov_r || out_ready) begin
          load = 1'b1;
          if (em_last[e_r]) begin
            clr       = 1'b1;
            state_nxt = B_TAKE;
          end else begin
            e_nxt = idx_t'(e_r + 1'b1);
          end
        end
      end
      default: begin
        state_nxt = B_TAKE;
      end
    endcase
  end

  // insert: sorted list makes beat monotone, so each slot keeps, shifts or takes new
  always_comb begin
    filled[TOP_K] = 1'b0;
    for (int i = 0; i < TOP_K; i++) begin
      beat[i]   = (cnts_r[i] == '0) || better(ins_cnt, ins_id, cnts_r[i], ids_r[i]);
      filled[i] = (cnts_r[i] != '0);
    end
    for (int i = 0; i < TOP_K; i++) begin
      em_last[i]  = !filled[i+1];
      ids_nxt[i]  = ids_r[i];
      cnts_nxt[i] = cnts_r[i];
      if (clr) begin
        cnts_nxt[i] = '0;
      end else if (ins_v && beat[i]) begin
        if (i == 0) begin
          ids_nxt[i]  = ins_id;
          cnts_nxt[i] = ins_cnt;
        end else if (!beat[(i > 0) ? i-1 : 0]) begin
          ids_nxt[i]  = ins_id;
          cnts_nxt[i] = ins_cnt;
        end else begin
          ids_nxt[i]  = ids_r[(i > 0) ? i-1 : 0];
          cnts_nxt[i] = cnts_r[(i > 0) ? i-1 : 0];
        end
      end
    end
  end

  always_comb begin
    ov_nxt = ov_r;
    if (load) begin
      ov_nxt = 1'b1;
    end else if (out_ready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_TAKE;
      e_r     <= '0;
      ov_r    <= 1'b0;
      for (int i = 0; i < TOP_K; i++) begin
        cnts_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      e_r     <= e_nxt;
      ov_r    <= ov_nxt;
      for (int i = 0; i < TOP_K; i++) begin
        cnts_r[i] <= cnts_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < TOP_K; i++) begin
      ids_r[i] <= ids_nxt[i];
    end
    if (cap) begin
      fin_id_r  <= q_data.fin_id;
      fin_cnt_r <= q_data.fin_cnt;
      src_r     <= q_data.src;
      tot_r     <= q_data.total;
    end
    if (load) begin
      o_src_r  <= src_r;
      o_tot_r  <= tot_r;
      o_rank_r <= RANK_W'(e_r);
      o_id_r   <= ids_r[e_r];
      o_cnt_r  <= cnts_r[e_r];
      o_last_r <= em_last[e_r];
    end
  end

  assign out_valid         = ov_r;
  assign out_src_node      = o_src_r;
  assign out_total_links   = o_tot_r;
  assign out_rank          = o_rank_r;
  assign out_partner_node  = o_id_r;
  assign out_partner_count = o_cnt_r;
  assign out_last          = o_last_r;

endmodule

### hw/rtl/top_partner_run_counter.sv
// Top level of the top partner run counter: front end, offer queue, top list.
// Depends on tprc_pkg, tprc_front, tprc_fifo and tprc_back.
//
//   channel   dir  handshake             payload
//   in_       in   in_valid / in_ready   src_id, dst_id, last_of_source
//   out_      out  out_valid / out_ready src_node, total_links, rank, partner_node,
//                                        partner_count, last
//
// One link beat is taken per cycle while the four-entry offer queue has room.
// The top list inserts one offered run per cycle in B_TAKE; a closing link then
// inserts its final run in B_FIN, and the result beats (up to TOP_K) are drained
// through the output register. The queue lets the front keep taking beats meanwhile.
// Reset (rst_n low, synchronous) empties the queue, the run state and the top list.
// Output stalls back up into the queue and then into in_ready.
module top_partner_run_counter
  import tprc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  id_t               in_src_id,
  input  id_t               in_dst_id,
  input  logic              in_last_of_source,
  output logic              out_valid,
  input  logic              out_ready,
  output id_t               out_src_node,
  output cnt_t              out_total_links,
  output logic [RANK_W-1:0] out_rank,
  output id_t               out_partner_node,
  output cnt_t              out_partner_count,
  output logic              out_last
);

  tprc_ofr_t wr_data;
  tprc_ofr_t rd_data;
  logic      push;
  logic      pop;
  logic      full;
  logic      empty;

  tprc_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_src_id         (in_src_id),
    .in_dst_id         (in_dst_id),
    .in_last_of_source (in_last_of_source),
    .q_full            (full),
    .q_push            (push),
    .q_data            (wr_data)
  );

  tprc_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (wr_data),
    .pop     (pop),
    .rd_data (rd_data),
    .full    (full),
    .empty   (empty)
  );

  tprc_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (empty),
    .q_data            (rd_data),
    .q_pop             (pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_src_node      (out_src_node),
    .out_total_links   (out_total_links),
    .out_rank          (out_rank),
    .out_partner_node  (out_partner_node),
    .out_partner_count (out_partner_count),
    .out_last          (out_last)
  );

endmodule

### tb/tprc_rank_checker.sv
// Checker for the top partner run counter: watches both channels, predicts the
// ranked partner results of each source and compares every result beat.
// Depends on tprc_pkg for the id, count and rank widths.
module tprc_rank_checker
  import tprc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  id_t               in_src_id,
  input  id_t               in_dst_id,
  input  logic              in_last_of_source,
  input  logic              out_valid,
  input  logic              out_ready,
  input  id_t               out_src_node,
  input  cnt_t              out_total_links,
  input  logic [RANK_W-1:0] out_rank,
  input  id_t               out_partner_node,
  input  cnt_t              out_partner_count,
  input  logic              out_last,
  output int                fail_count,
  output int                waiting,
  output int                results_checked
);

  typedef struct {
    id_t               src;
    cnt_t              total;
    logic [RANK_W-1:0] rank;
    id_t               partner;
    cnt_t              count;
    logic              last;
  } ranked_t;

  ranked_t ranked_q[$];

  id_t  open_partner;
  cnt_t open_len;
  cnt_t src_links;
  logic src_open;
  id_t  top_id [TOP_K];
  cnt_t top_cnt[TOP_K];
  int   mismatches;
  int   checked;

  assign fail_count      = mismatches;
  assign results_checked = checked;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic match_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  task automatic clear_group();
    open_partner = '0;
    open_len     = '0;
    src_links    = '0;
    src_open     = 1'b0;
    for (int i = 0; i < TOP_K; i++) begin
      top_id[i]  = '0;
      top_cnt[i] = '0;
    end
  endtask

  // insert a closed run; drop it when it cannot beat the tail of a full list
  task automatic offer_run(input id_t pid, input cnt_t len);
    int slot;
    slot = TOP_K;
    for (int i = 0; i < TOP_K; i++) begin
      if (top_cnt[i] == '0 || len > top_cnt[i] ||
          (len == top_cnt[i] && pid > top_id[i])) begin
        slot = i;
        break;
      end
    end
    for (int i = TOP_K - 1; i > slot; i--) begin
      top_id[i]  = top_id[i-1];
      top_cnt[i] = top_cnt[i-1];
    end
    if (slot < TOP_K) begin
      top_id[slot]  = pid;
      top_cnt[slot] = len;
    end
  endtask

  task automatic take_link(input id_t src, input id_t dst, input logic fin);
    ranked_t r;
    if (!src_open) begin
      clear_group();
      open_partner = dst;
      open_len     = 1;
      src_links    = 1;
      src_open     = 1'b1;
    end else begin
      if (src_links != '1) src_links++;
      if (dst == open_partner) begin
        if (open_len != '1) open_len++;
      end else begin
        offer_run(open_partner, open_len);
        open_partner = dst;
        open_len     = 1;
      end
    end
    if (fin) begin
      offer_run(open_partner, open_len);
      for (int i = 0; i < TOP_K; i++) begin
        if (top_cnt[i] == '0) break;
        r.src     = src;
        r.total   = src_links;
        r.rank    = RANK_W'(i);
        r.partner = top_id[i];
        r.count   = top_cnt[i];
        r.last    = (i == TOP_K - 1) || (top_cnt[i+1] == '0);
        ranked_q.push_back(r);
      end
      clear_group();
    end
  endtask

  always @(posedge clk) begin
    ranked_t want;
    if (!rst_n) begin
      clear_group();
      ranked_q.delete();
      mismatches = 0;
      checked    = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (ranked_q.size() == 0) begin
          report_mismatch("result beat with nothing expected");
        end else begin
          want = ranked_q.pop_front();
          match_field("src_node", 32'(out_src_node), 32'(want.src));
          match_field("total_links", out_total_links, want.total);
          match_field("rank", 32'(out_rank), 32'(want.rank));
          match_field("partner_node", 32'(out_partner_node), 32'(want.partner));
          match_field("partner_count", out_partner_count, want.count);
          match_field("last", 32'(out_last), 32'(want.last));
          checked++;
        end
      end
      if (in_valid && in_ready)
        take_link(in_src_id, in_dst_id, in_last_of_source);
    end
    waiting <= ranked_q.size();
  end

endmodule

### tb/tb_top_partner_run_counter.sv
// Testbench top for the top partner run counter: clock, reset, link stimulus
// and the receiver's stall pattern; tprc_rank_checker does all the checking.
// Depends on tprc_pkg, top_partner_run_counter and tprc_rank_checker.
module tb_top_partner_run_counter;
  import tprc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 150;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  id_t               in_src_id;
  id_t               in_dst_id;
  logic              in_last_of_source;
  logic              out_valid;
  logic              out_ready;
  id_t               out_src_node;
  cnt_t              out_total_links;
  logic [RANK_W-1:0] out_rank;
  id_t               out_partner_node;
  cnt_t              out_partner_count;
  logic              out_last;

  int   fail_count;
  int   waiting;
  int   results_checked;
  int   links_sent;
  int   send_idle_pct;
  int   stall_pct;
  int   cycle_count;
  logic hold_req;
  logic hold_served;

  top_partner_run_counter dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_src_id         (in_src_id),
    .in_dst_id         (in_dst_id),
    .in_last_of_source (in_last_of_source),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_src_node      (out_src_node),
    .out_total_links   (out_total_links),
    .out_rank          (out_rank),
    .out_partner_node  (out_partner_node),
    .out_partner_count (out_partner_count),
    .out_last          (out_last)
  );

  tprc_rank_checker checker_i (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_src_id         (in_src_id),
    .in_dst_id         (in_dst_id),
    .in_last_of_source (in_last_of_source),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_src_node      (out_src_node),
    .out_total_links   (out_total_links),
    .out_rank          (out_rank),
    .out_partner_node  (out_partner_node),
    .out_partner_count (out_partner_count),
    .out_last          (out_last),
    .fail_count        (fail_count),
    .waiting           (waiting),
    .results_checked   (results_checked)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_ready   <= 1'b0;
    hold_served  = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_served) begin
        hold_served = 1'b1;
        out_ready <= 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // offer one link beat, hold it until taken, then idle at random
  task automatic send_link(input id_t src, input id_t dst, input logic fin);
    in_src_id         <= src;
    in_dst_id         <= dst;
    in_last_of_source <= fin;
    in_valid          <= 1'b1;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    links_sent++;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  // one source: sorted partner runs, or unsorted noise with drifting src ids
  task automatic send_source(input logic tidy);
    id_t         src;
    id_t         dst;
    id_t         alt_a;
    id_t         alt_b;
    int unsigned runs;
    int unsigned len;
    src = id_t'($urandom);
    if (tidy) begin
      runs = $urandom_range(1, 12);
      dst  = id_t'($urandom_range(0, 20'h7FFFF));
      for (int r = 0; r < runs; r++) begin
        len = $urandom_range(1, 2);
        for (int k = 0; k < len; k++)
          send_link(src, dst, (r == runs - 1) && (k == len - 1));
        dst = dst + id_t'($urandom_range(1, 30000));
      end
    end else begin
      len   = $urandom_range(1, 12);
      alt_a = id_t'($urandom);
      alt_b = id_t'($urandom);
      for (int k = 0; k < len; k++) begin
        case ($urandom_range(2))
          0:       dst = alt_a;
          1:       dst = alt_b;
          default: dst = id_t'($urandom);
        endcase
        if ($urandom_range(3) == 0) src = id_t'($urandom);
        send_link(src, dst, k == len - 1);
      end
    end
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
  endtask

  initial begin
    int idle_mix [4];
    int stall_mix[4];
    int phase_end;
    idle_mix  = '{0, 78, 0, 35};
    stall_mix = '{0, 0, 78, 35};
    rst_n             <= 1'b0;
    in_valid          <= 1'b0;
    in_src_id         <= '0;
    in_dst_id         <= '0;
    in_last_of_source <= 1'b0;
    hold_req          <= 1'b0;
    links_sent         = 0;
    send_idle_pct      = 0;
    stall_pct          = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    send_link('0, '0, 1'b1);
    send_link('1, '1, 1'b1);
    // equal counts: larger partner id ranks first
    send_link(id_t'(5), id_t'(3), 1'b0);
    send_link(id_t'(5), id_t'(3), 1'b0);
    send_link(id_t'(5), id_t'(7), 1'b0);
    send_link(id_t'(5), id_t'(7), 1'b0);
    send_link(id_t'(5), id_t'(1), 1'b1);
    // returning partner opens a second run of the same id
    send_link(id_t'(6), id_t'(4), 1'b0);
    send_link(id_t'(6), id_t'(9), 1'b0);
    send_link(id_t'(6), id_t'(4), 1'b1);
    // src id drifts without a closing flag
    send_link(id_t'(10), id_t'(2), 1'b0);
    send_link(id_t'(11), id_t'(2), 1'b0);
    send_link(id_t'(12), id_t'(3), 1'b1);
    // more runs than slots, weakest arriving last: tail runs dropped
    for (int i = 0; i < 12; i++)
      send_link(id_t'(7), id_t'(20 - i), i == 11);

    // hold the receiver while single-link sources keep coming, so the queue backs up
    hold_req <= 1'b1;
    for (int i = 0; i < 12; i++)
      send_link(id_t'(40 + i), id_t'(i * 3), 1'b1);
    wait_results();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_mix[ph];
      stall_pct     = stall_mix[ph];
      phase_end     = links_sent + 16;
      while (links_sent < phase_end) send_source($urandom_range(99) < 75);
    end

    wait_results();
    repeat (64) @(posedge clk);
    $display("Sent %0d links (directed ties, overflow, drifting ids, unsorted runs),",
             links_sent);
    $display("checked %0d ranked results over four idle/stall mixes and a long hold-off.",
             results_checked);
    if (fail_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
